[rtl/assert_macros.svh]
// Assertion macros shared by the directory RTL.
// Each macro samples on clk_i and is switched off while rst_ni is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every sampled edge.
`define RCTD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// The condition must never be true at a sampled edge.
`define RCTD_ASSERT_NEVER(lbl, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) else $error(msg);

`endif

[rtl/rctd_pkg.sv]
// Package of the reuse-cache tag/data directory: sizes, item and result types,
// tag and data row layouts. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package rctd_pkg;

  localparam int unsigned TAG_SETS  = 1024;
  localparam int unsigned TAG_WAYS  = 16;
  localparam int unsigned DATA_SETS = 256;
  localparam int unsigned DATA_WAYS = 16;
  localparam int unsigned ADDR_W    = 58;
  localparam int unsigned DATA_W    = 64;

  localparam int unsigned TSET_W   = $clog2(TAG_SETS);
  localparam int unsigned TWAY_W   = $clog2(TAG_WAYS);
  localparam int unsigned DSET_W   = (DATA_SETS > 1) ? $clog2(DATA_SETS) : 1;
  localparam int unsigned DWAY_W   = $clog2(DATA_WAYS);
  localparam int unsigned CLR_ROWS = (TAG_SETS > DATA_SETS) ? TAG_SETS : DATA_SETS;
  localparam int unsigned CLR_W    = $clog2(CLR_ROWS);
  localparam int unsigned QDEPTH   = 2;
  localparam int unsigned QPTR_W   = $clog2(QDEPTH);
  localparam int unsigned QCNT_W   = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    KIND_READ = 2'd0,
    KIND_FILL = 2'd1,
    KIND_WB   = 2'd2,
    KIND_INV  = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e              kind;
    logic [ADDR_W-1:0]  block_address;
    logic [DATA_W-1:0]  write_data;
    logic               lower_queue_full;
  } item_t;

  typedef struct packed {
    logic               stalled;
    logic               hit;
    logic [DATA_W-1:0]  read_data;
    logic               wb_valid;
    logic [ADDR_W-1:0]  wb_address;
    logic [DATA_W-1:0]  wb_data;
    logic               last;
  } result_t;

  typedef struct packed {
    item_t              item;
    logic [TSET_W-1:0]  tset;
    logic [DSET_W-1:0]  dset;
  } job_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  typedef struct packed {
    logic               valid;
    logic               has_data;
    logic               not_reused;
    logic [DWAY_W-1:0]  data_way;
    logic [ADDR_W-1:0]  block_address;
  } tag_ent_t;

  typedef struct packed {
    logic               valid;
    logic               dirty;
    logic               not_used;
    logic [DATA_W-1:0]  value;
    logic [ADDR_W-1:0]  block_address;
    logic [TWAY_W-1:0]  owner_tag;
  } data_ent_t;

  typedef tag_ent_t  [TAG_WAYS-1:0]  tag_row_t;
  typedef data_ent_t [DATA_WAYS-1:0] data_row_t;

  // Data set of a tag set: the tag set taken modulo DATA_SETS.
  function automatic logic [DSET_W-1:0] dset_of(input logic [TSET_W-1:0] s);
    logic [TSET_W+DSET_W-1:0] wide;
    wide = {{DSET_W{1'b0}}, s};
    if (DATA_SETS == 1) begin
      return '0;
    end
    return wide[DSET_W-1:0];
  endfunction

endpackage
`default_nettype wire

[rtl/rctd_front.sv]
// Front end of the directory: takes items on the start/busy handshake and
// works out their tag and data sets. Depends on rctd_pkg.
`timescale 1ns / 1ps
`default_nettype none
module rctd_front (
  input  logic             start,
  output logic             busy,
  input  rctd_pkg::item_t  item_i,
  input  logic             clearing_i,
  input  rctd_pkg::q_stat_t q_stat_i,
  output logic             push_o,
  output rctd_pkg::job_t   job_o
);
  import rctd_pkg::*;

  assign busy   = clearing_i | q_stat_i.full;
  assign push_o = start & ~busy;

  always_comb begin
    job_o      = '0;
    job_o.item = item_i;
    job_o.tset = item_i.block_address[TSET_W-1:0];
    job_o.dset = dset_of(item_i.block_address[TSET_W-1:0]);
  end

endmodule
`default_nettype wire

[rtl/rctd_queue.sv]
// Short job queue between the front end and the back end of the directory.
// Depends on rctd_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module rctd_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  rctd_pkg::job_t     job_i,
  input  logic               pop_i,
  output rctd_pkg::job_t     job_o,
  output rctd_pkg::q_stat_t  stat_o
);
  import rctd_pkg::*;

  job_t              slot_q [QDEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_q] <= job_i;
    end
  end

  assign job_o        = slot_q[rd_q];
  assign stat_o.full  = (cnt_q == QCNT_W'(QDEPTH));
  assign stat_o.empty = (cnt_q == '0);

  `RCTD_ASSERT(a_q_count, cnt_q <= QCNT_W'(QDEPTH), "queue count beyond depth")
  `RCTD_ASSERT_NEVER(a_q_pop_empty, pop_i && stat_o.empty, "pop from empty queue")

endmodule
`default_nettype wire

[rtl/rctd_back.sv]
// Back end of the directory: holds the tag and data row memories, clears them
// after reset and carries out each job. Depends on rctd_pkg, assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module rctd_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  rctd_pkg::q_stat_t  q_stat_i,
  input  rctd_pkg::job_t     job_i,
  output logic               pop_o,
  output logic               clearing_o,
  output logic               res_valid_o,
  output rctd_pkg::result_t  res_o
);
  import rctd_pkg::*;

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_EXEC  = 5'b00100,
    S_REL   = 5'b01000,
    S_OUT2  = 5'b10000
  } state_e;

  state_e            state_q, state_d;
  logic [CLR_W-1:0]  clr_q, clr_d;
  job_t              job_q;
  result_t           res_q, res_d, wb2_q, wb2_d;
  logic              res_valid_q, res_valid_d;
  logic [TSET_W-1:0] rel_set_q, rel_set_d;
  logic [TWAY_W-1:0] rel_way_q, rel_way_d;
  logic [ADDR_W-1:0] rel_addr_q, rel_addr_d;
  logic [DWAY_W-1:0] rel_v_q, rel_v_d;

  tag_row_t          tmem [TAG_SETS];
  data_row_t         dmem [DATA_SETS];
  tag_row_t          trow_q, t_wdata;
  data_row_t         drow_q, d_wdata;
  logic              t_we, d_we;
  logic [TSET_W-1:0] t_waddr, t_raddr;
  logic [DSET_W-1:0] d_waddr;

  // Lookup and victim choice on the rows read for the current job.
  logic              t_found, t_inv_f, t_nr_f, t_wipe;
  logic [TWAY_W-1:0] tw, t_inv_w, t_nr_w, tvict;
  logic              d_inv_f, d_nu_f, d_wipe;
  logic [DWAY_W-1:0] d_inv_w, d_nu_w, dvict;

  always_comb begin
    t_found = 1'b0;
    tw      = '0;
    t_inv_f = 1'b0;
    t_inv_w = '0;
    t_nr_f  = 1'b0;
    t_nr_w  = '0;
    for (int i = TAG_WAYS - 1; i >= 0; i--) begin
      if (trow_q[i].valid && trow_q[i].block_address == job_q.item.block_address) begin
        t_found = 1'b1;
        tw      = TWAY_W'(i);
      end
      if (!trow_q[i].valid) begin
        t_inv_f = 1'b1;
        t_inv_w = TWAY_W'(i);
      end
      if (trow_q[i].not_reused) begin
        t_nr_f = 1'b1;
        t_nr_w = TWAY_W'(i);
      end
    end
    t_wipe = !t_inv_f && !t_nr_f;
    tvict  = t_inv_f ? t_inv_w : (t_nr_f ? t_nr_w : '0);
  end

  always_comb begin
    d_inv_f = 1'b0;
    d_inv_w = '0;
    d_nu_f  = 1'b0;
    d_nu_w  = '0;
    for (int i = DATA_WAYS - 1; i >= 0; i--) begin
      if (!drow_q[i].valid) begin
        d_inv_f = 1'b1;
        d_inv_w = DWAY_W'(i);
      end
      if (drow_q[i].not_used) begin
        d_nu_f = 1'b1;
        d_nu_w = DWAY_W'(i);
      end
    end
    d_wipe = !d_inv_f && !d_nu_f;
    dvict  = d_inv_f ? d_inv_w : (d_nu_f ? d_nu_w : '0);
  end

  tag_ent_t          te, tv_ent;
  data_ent_t         de, tvd, dv_ent;
  logic              ft_holds, ft_dirty, fd_dirty, own_local;
  logic [TSET_W-1:0] own_set;
  logic [TWAY_W-1:0] own_way;

  always_comb begin
    te        = trow_q[tw];
    de        = drow_q[te.data_way];
    tv_ent    = trow_q[tvict];
    tvd       = drow_q[tv_ent.data_way];
    ft_holds  = tv_ent.valid && tv_ent.has_data;
    ft_dirty  = ft_holds && tvd.valid && tvd.dirty;
    dv_ent    = drow_q[dvict];
    fd_dirty  = dv_ent.valid && dv_ent.dirty;
    own_set   = dv_ent.block_address[TSET_W-1:0];
    own_way   = dv_ent.owner_tag;
    own_local = (own_set == job_q.tset);
  end

  // Execution of one job on its tag row and data row.
  tag_row_t          nt;
  data_row_t         nd;
  logic              stall, hit, do_fd, do_ft, mark_dirty, need_rel, full;
  logic [DATA_W-1:0] rdata, wd, wb_d0, wb_d1;
  logic [ADDR_W-1:0] addr, wb_a0, wb_a1;
  logic [1:0]        nwb;

  always_comb begin
    nt         = trow_q;
    nd         = drow_q;
    stall      = 1'b0;
    hit        = 1'b0;
    rdata      = '0;
    do_fd      = 1'b0;
    do_ft      = 1'b0;
    mark_dirty = 1'b0;
    need_rel   = 1'b0;
    nwb        = '0;
    wb_a0      = '0;
    wb_d0      = '0;
    wb_a1      = '0;
    wb_d1      = '0;
    addr       = job_q.item.block_address;
    wd         = job_q.item.write_data;
    full       = job_q.item.lower_queue_full;

    case (job_q.item.kind)
      KIND_READ: begin
        if (t_found && te.has_data) begin
          hit                     = 1'b1;
          nt[tw].not_reused       = 1'b0;
          nd[te.data_way].not_used = 1'b0;
          rdata                   = de.value;
        end
      end
      KIND_FILL: begin
        rdata = wd;
        if (t_found) begin
          if (te.has_data) begin
            rdata                    = de.value;
            nt[tw].not_reused        = 1'b0;
            nd[te.data_way].not_used = 1'b1;
          end else begin
            do_fd = 1'b1;
          end
        end else begin
          do_ft = 1'b1;
        end
      end
      KIND_WB: begin
        if (t_found) begin
          if (te.has_data) begin
            nd[te.data_way].value    = wd;
            nd[te.data_way].dirty    = 1'b1;
            nt[tw].not_reused        = 1'b0;
            nd[te.data_way].not_used = 1'b1;
          end else begin
            do_fd      = 1'b1;
            mark_dirty = 1'b1;
          end
        end else if (full) begin
          stall = 1'b1;
        end else begin
          // The block goes straight down before a tag is made for it.
          wb_a0 = addr;
          wb_d0 = wd;
          nwb   = 2'd1;
          do_ft = 1'b1;
        end
      end
      KIND_INV: begin
        if (t_found) begin
          hit             = 1'b1;
          nt[tw].valid    = 1'b0;
          nt[tw].has_data = 1'b0;
        end
      end
      default: begin
      end
    endcase

    if (do_fd) begin
      if (fd_dirty && full) begin
        stall = 1'b1;
      end else begin
        if (d_wipe) begin
          for (int i = 0; i < DATA_WAYS; i++) begin
            nd[i].not_used = 1'b1;
          end
        end
        if (dv_ent.valid) begin
          if (dv_ent.dirty) begin
            wb_a0 = dv_ent.block_address;
            wb_d0 = dv_ent.value;
            nwb   = 2'd1;
          end
          // The evicted entry's owner loses its data mark if it still points here.
          if (own_local) begin
            if (trow_q[own_way].valid && trow_q[own_way].has_data &&
                trow_q[own_way].block_address == dv_ent.block_address &&
                trow_q[own_way].data_way == dvict) begin
              nt[own_way].has_data = 1'b0;
            end
          end else begin
            need_rel = 1'b1;
          end
        end
        nd[dvict].valid         = 1'b1;
        nd[dvict].dirty         = mark_dirty;
        nd[dvict].not_used      = 1'b1;
        nd[dvict].value         = wd;
        nd[dvict].block_address = addr;
        nd[dvict].owner_tag     = tw;
        nt[tw].has_data         = 1'b1;
        nt[tw].data_way         = dvict;
        nt[tw].not_reused       = 1'b0;
      end
    end

    if (do_ft) begin
      if (ft_dirty && full) begin
        stall = 1'b1;
      end else begin
        if (t_wipe) begin
          for (int i = 0; i < TAG_WAYS; i++) begin
            nt[i].not_reused = 1'b1;
          end
        end
        if (ft_holds && tvd.valid) begin
          if (ft_dirty) begin
            if (nwb == 2'd0) begin
              wb_a0 = tvd.block_address;
              wb_d0 = tvd.value;
            end else begin
              wb_a1 = tvd.block_address;
              wb_d1 = tvd.value;
            end
            nwb = nwb + 2'd1;
          end
          nd[tv_ent.data_way].valid = 1'b0;
          nd[tv_ent.data_way].dirty = 1'b0;
        end
        nt[tvict].valid         = 1'b1;
        nt[tvict].has_data      = 1'b0;
        nt[tvict].not_reused    = 1'b1;
        nt[tvict].data_way      = '0;
        nt[tvict].block_address = addr;
      end
    end
  end

  // Remote release: the owner row was read at the end of the execute cycle.
  tag_row_t rrow;

  always_comb begin
    rrow = trow_q;
    if (trow_q[rel_way_q].valid && trow_q[rel_way_q].has_data &&
        trow_q[rel_way_q].block_address == rel_addr_q &&
        trow_q[rel_way_q].data_way == rel_v_q) begin
      rrow[rel_way_q].has_data = 1'b0;
    end
  end

  // Sequencer.
  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    pop_o       = 1'b0;
    t_we        = 1'b0;
    d_we        = 1'b0;
    t_waddr     = job_q.tset;
    d_waddr     = job_q.dset;
    t_wdata     = nt;
    d_wdata     = nd;
    t_raddr     = job_i.tset;
    res_valid_d = 1'b0;
    res_d       = '0;
    wb2_d       = wb2_q;
    rel_set_d   = rel_set_q;
    rel_way_d   = rel_way_q;
    rel_addr_d  = rel_addr_q;
    rel_v_d     = rel_v_q;

    case (state_q)
      S_CLEAR: begin
        t_we    = 1'b1;
        d_we    = 1'b1;
        t_waddr = clr_q[TSET_W-1:0];
        d_waddr = clr_q[DSET_W-1:0];
        t_wdata = '0;
        d_wdata = '0;
        clr_d   = clr_q + 1'b1;
        if (clr_q == CLR_W'(CLR_ROWS - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (!q_stat_i.empty) begin
          pop_o   = 1'b1;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        t_raddr     = own_set;
        res_valid_d = 1'b1;
        state_d     = S_IDLE;
        if (stall) begin
          res_d.stalled = 1'b1;
          res_d.last    = 1'b1;
        end else begin
          t_we             = 1'b1;
          d_we             = 1'b1;
          res_d.hit        = hit;
          res_d.read_data  = rdata;
          res_d.wb_valid   = (nwb != 2'd0);
          res_d.wb_address = wb_a0;
          res_d.wb_data    = wb_d0;
          res_d.last       = (nwb != 2'd2);
          wb2_d            = '0;
          wb2_d.wb_valid   = 1'b1;
          wb2_d.wb_address = wb_a1;
          wb2_d.wb_data    = wb_d1;
          wb2_d.last       = 1'b1;
          rel_set_d        = own_set;
          rel_way_d        = own_way;
          rel_addr_d       = dv_ent.block_address;
          rel_v_d          = dvict;
          if (need_rel) begin
            state_d = S_REL;
          end else if (nwb == 2'd2) begin
            state_d = S_OUT2;
          end
        end
      end
      S_REL: begin
        t_we    = 1'b1;
        t_waddr = rel_set_q;
        t_wdata = rrow;
        state_d = S_IDLE;
      end
      S_OUT2: begin
        res_valid_d = 1'b1;
        res_d       = wb2_q;
        state_d     = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      job_q <= job_i;
    end
    res_q      <= res_d;
    wb2_q      <= wb2_d;
    rel_set_q  <= rel_set_d;
    rel_way_q  <= rel_way_d;
    rel_addr_q <= rel_addr_d;
    rel_v_q    <= rel_v_d;
  end

  always_ff @(posedge clk_i) begin
    if (t_we) begin
      tmem[t_waddr] <= t_wdata;
    end
    trow_q <= tmem[t_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (d_we) begin
      dmem[d_waddr] <= d_wdata;
    end
    drow_q <= dmem[job_i.dset];
  end

  assign clearing_o  = (state_q == S_CLEAR);
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  `RCTD_ASSERT(a_stall_alone, res_valid_q && res_q.stalled |-> res_q.last && !res_q.wb_valid && !res_q.hit, "stalled result carries more than the stall")
  `RCTD_ASSERT(a_out2_first, state_q == S_OUT2 |-> res_valid_q && !res_q.last && res_q.wb_valid, "second writeback without a first")
  `RCTD_ASSERT(a_rel_single, state_q == S_REL |-> res_valid_q && res_q.last, "release after a multi-result item")
  `RCTD_ASSERT_NEVER(a_clear_pop, state_q == S_CLEAR && pop_o, "job taken during the clearing pass")

endmodule
`default_nettype wire

[rtl/reuse_cache_tag_data_directory.sv]
// Top level of the reuse-cache tag/data directory: front end, job queue and
// back end. Depends on rctd_pkg, rctd_front, rctd_queue and rctd_back.
`timescale 1ns / 1ps
`default_nettype none
// Usage:
// An item (read, fill, writeback or invalidate of one block address) is
// transferred at a rising edge where start is high and busy is low. The front
// end works out its tag set and data set and places it in a two-entry queue.
// The back end reads the tag row and the data row of the item as it takes the
// item from the queue (S_IDLE) and carries the item out in the next cycle (S_EXEC), writing both rows back.
// Each result is shown on result_o for exactly one cycle, marked by
// result_valid_o; the receiver cannot hold results back. The first result
// of an item is registered at the end of its S_EXEC step.
// S_REL follows S_EXEC when an evicted data entry must clear the data mark of
// a tag in another tag set (a second access of the tag memory port), and
// S_OUT2 follows it when the item causes two lower writebacks and the second
// result is shown on its own.
// After reset, busy stays high while both memories are cleared, one row per
// cycle, over CLR_ROWS (1024) rows.
// A stalled item returns one result with stalled set and changes nothing;
// it is the sender's job to present it again.
module reuse_cache_tag_data_directory (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  rctd_pkg::item_t    item_i,
  output logic               result_valid_o,
  output rctd_pkg::result_t  result_o
);
  import rctd_pkg::*;

  logic    push, pop, clearing;
  job_t    job_in, job_out;
  q_stat_t q_stat;

  // Front end: handshake and set decode.
  rctd_front u_front (
    .start      (start),
    .busy       (busy),
    .item_i     (item_i),
    .clearing_i (clearing),
    .q_stat_i   (q_stat),
    .push_o     (push),
    .job_o      (job_in)
  );

  // Queue lets the front keep taking items while the back end works.
  rctd_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (job_in),
    .pop_i  (pop),
    .job_o  (job_out),
    .stat_o (q_stat)
  );

  // Back end: memories, clearing pass and execution of each transfer.
  rctd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_stat_i    (q_stat),
    .job_i       (job_out),
    .pop_o       (pop),
    .clearing_o  (clearing),
    .res_valid_o (result_valid_o),
    .res_o       (result_o)
  );

endmodule
`default_nettype wire
